// ----- rtl/slcorr_pkg.sv -----
`timescale 1ns / 1ps

package slcorr_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 64;
    localparam int TAPCNT_W  = 9;
    localparam int POS_W     = 8;
    localparam int OP_W      = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_TAP_COUNT = '0;
    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 9'd256;

    // transaction opcodes
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // control from sequencer to multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic valid;
        logic first;
    } mac_ctl_t;

endpackage

// ----- rtl/slcorr_ram.sv -----
`timescale 1ns / 1ps

module slcorr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/slcorr_mac.sv -----
`timescale 1ns / 1ps

module slcorr_mac
    import slcorr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] tap_data,
    input  logic signed [SAMPLE_W-1:0] hist_data,
    output logic signed [ACC_W-1:0]    acc,
    output logic                       busy
);

    mac_ctl_t                   ctl_d_reg;
    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] opnd;
    logic signed [ACC_W-1:0]    acc_reg;

    // align control with the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg      <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_d_reg      <= ctl;
            prod_valid_reg <= ctl_d_reg.valid;
        end
    end

    // tap 0 pairs with the new sample, later taps with history
    always_comb
    begin
        opnd      = ctl_d_reg.first ? sample : hist_data;
        prod_next = tap_data * opnd;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = ctl_d_reg.valid | prod_valid_reg;

endmodule

// ----- rtl/sliding_correlator_s16_core.sv -----
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+---------------------------------
// input     | in_valid / in_ready  | op, value, ref_position
// output    | out_valid / out_ready| correlation
// config    | psel/penable/pready  | paddr, pwdata, prdata (tap_count)
//
// a sample reads max(n,1) taps before the next acceptance, n the
// taps in use; one multiply-accumulate walks the taps, one tap and history read per cycle
// a load writes one tap and leaves the unit ready; a clear sweeps the MAX_TAPS-1 history entries
// after reset the same sweep zeroes the history before in_ready rises
// a finished result waits in the output register; the next sample may run meanwhile
// and holds at its end until the output register is free

module sliding_correlator_s16_core
    import slcorr_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input transactions
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OP_W-1:0]              op,
    input  logic signed [SAMPLE_W-1:0]   value,
    input  logic [POS_W-1:0]             ref_position,
    // result transactions
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ACC_W-1:0]      correlation,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int HD = MAX_TAPS - 1;
    localparam int TW = $clog2(MAX_TAPS);
    localparam int HW = (HD > 1) ? $clog2(HD) : 1;
    localparam int NW = $clog2(MAX_TAPS + 1);

    state_t                      state_reg, state_next;
    logic [TW-1:0]               idx_reg, idx_next;
    logic [HW-1:0]               haddr_reg, haddr_next;
    logic [HW-1:0]               ptr_reg, ptr_next;
    logic [HW-1:0]               sweep_reg, sweep_next;
    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [TAPCNT_W-1:0]         tap_count_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]     corr_reg, corr_next;

    logic [NW-1:0]               n_eff;
    logic [TW-1:0]               last_idx;
    logic [TW-1:0]               tap_waddr;
    logic                        tap_we;
    logic                        hist_we;
    logic [HW-1:0]               hist_waddr;
    logic signed [SAMPLE_W-1:0]  hist_wdata;
    logic                        rd_en;
    logic signed [SAMPLE_W-1:0]  tap_rdata;
    logic signed [SAMPLE_W-1:0]  hist_rdata;
    mac_ctl_t                    mac_ctl;
    logic signed [ACC_W-1:0]     mac_acc;
    logic                        mac_busy;
    logic                        cfg_hit;

    // configuration register
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            tap_count_reg <= pwdata[TAPCNT_W-1:0];
        end
    end

    assign prdata = cfg_hit ? APB_DATA_W'(tap_count_reg) : '0;
    assign pready = 1'b1;

    // taps in use, saturated to the tap memory depth
    always_comb
    begin
        if (int'(tap_count_reg) > MAX_TAPS)
        begin
            n_eff = NW'(MAX_TAPS);
        end
        else
        begin
            n_eff = NW'(tap_count_reg);
        end
        last_idx  = (n_eff == '0) ? '0 : TW'(int'(n_eff) - 1);
        tap_waddr = TW'(int'(n_eff) - 1 - int'(ref_position));
    end

    // sequencer state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        haddr_reg  <= haddr_next;
        sample_reg <= sample_next;
        corr_reg   <= corr_next;
    end

    // next state and control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        haddr_next     = haddr_reg;
        ptr_next       = ptr_reg;
        sweep_next     = sweep_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        corr_next      = corr_reg;
        in_ready       = 1'b0;
        tap_we         = 1'b0;
        hist_we        = 1'b0;
        hist_waddr     = sweep_reg;
        hist_wdata     = '0;
        rd_en          = 1'b0;
        mac_ctl        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                hist_we = 1'b1;
                if (sweep_reg == HW'(HD - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op)
                        OP_SAMPLE:
                        begin
                            sample_next   = value;
                            idx_next      = '0;
                            haddr_next    = ptr_reg;
                            mac_ctl.start = 1'b1;
                            state_next    = ST_RUN;
                        end
                        OP_LOAD:
                        begin
                            tap_we = (int'(ref_position) < int'(n_eff));
                        end
                        OP_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (idx_reg == '0);
                haddr_next    = (haddr_reg == '0) ? HW'(HD - 1) : haddr_reg - 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    corr_next      = mac_acc;
                    hist_we        = 1'b1;
                    hist_waddr     = ptr_reg;
                    hist_wdata     = sample_reg;
                    ptr_next       = (ptr_reg == HW'(HD - 1)) ? '0 : ptr_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reference tap memory
    slcorr_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_W),
        .AW    (TW)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (value),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (tap_rdata)
    );

    // sample history memory
    slcorr_ram #(
        .DEPTH (HD),
        .WIDTH (SAMPLE_W),
        .AW    (HW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (rd_en),
        .raddr (haddr_reg),
        .rdata (hist_rdata)
    );

    // shared multiply-accumulate
    slcorr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .sample    (sample_reg),
        .tap_data  (tap_rdata),
        .hist_data (hist_rdata),
        .acc       (mac_acc),
        .busy      (mac_busy)
    );

    assign out_valid   = out_valid_reg;
    assign correlation = corr_reg;

endmodule

// ----- rtl/slcorr_checker.sv -----
`timescale 1ns / 1ps

module slcorr_checker
    import slcorr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [OP_W-1:0]     op,
    input logic                out_valid,
    input logic                out_ready,
    input logic [ACC_W-1:0]    correlation
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(correlation))
        else $error("stalled result changed or dropped");

    // a sample keeps in_ready low after its acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_SAMPLE |=> !in_ready ##1 !in_ready)
        else $error("input taken while a sample is in flight");

    // a clear sweeps the history before taking more input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_CLEAR |=> !in_ready)
        else $error("input taken during history clear");

    // a new result only appears at the end of a sample run
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a sample run");

endmodule

bind sliding_correlator_s16_core slcorr_checker u_slcorr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .correlation (correlation)
);
